// ===== design/assert_macros.svh =====
// assertion macros shared by the selector rtl
// expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/bsel_pkg.sv =====
// types, constants and helpers for the backend selector
// no dependencies
package bsel_pkg;

    localparam int NUM_GROUPS   = 4;
    localparam int NUM_BACKENDS = 8;
    localparam int COUNT_WIDTH  = 16;
    localparam int NUM_CNT_REGS = 4;

    localparam int G_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int IDX_W  = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;
    localparam int SIZE_W = $clog2(NUM_BACKENDS + 1);
    localparam int LVL    = $clog2(NUM_BACKENDS);
    localparam int NBP    = 1 << LVL;
    localparam int LVL_W  = $clog2(LVL + 2);
    localparam int CMP_W  = 8;

    localparam int OPCODE_W   = 2;
    localparam int GROUP_W    = 2;
    localparam int BIDX_W     = 3;
    localparam int AG_W       = 3;
    localparam int MASK_W     = 4;
    localparam int BCNT_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SELECT = 2'd0,
        OP_OPEN   = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_HEALTH = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GROUPS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LC_MASK       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKENDS0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKENDS3     = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_REDUCE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    typedef struct packed {
        logic                   live;
        logic [COUNT_WIDTH-1:0] cnt;
    } entry_t;

    typedef entry_t [NUM_BACKENDS-1:0] row_t;

    typedef struct packed {
        logic                   valid;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [IDX_W-1:0]       idx;
    } cand_t;

    function automatic row_t reset_row();
        row_t r;
        for (int i = 0; i < NUM_BACKENDS; i++) begin
            r[i].live = 1'b1;
            r[i].cnt  = '0;
        end
        return r;
    endfunction

    // lower index wins ties
    function automatic cand_t better(cand_t a, cand_t b);
        if (a.valid && (!b.valid || a.cnt <= b.cnt)) begin
            return a;
        end
        return b;
    endfunction

endpackage

// ===== design/backend_selector_rr_least_conn.sv =====
// backend selector top level: row memory, round-robin and least-connections search
// depends on bsel_pkg and assert_macros.svh
`include "assert_macros.svh"

// Each group's backends sit in one memory row ({live, count} per backend), read into a
// register in S_READ and written back after an update. One item is worked at a time:
// a round-robin select or an update passes S_READ, S_EXEC and S_OUT; a least-connections
// select also passes S_REDUCE, where the minimum search halves a registered candidate
// list once per cycle. The next input is taken as soon as the previous result sits in
// the output register. A row never written since reset reads as all backends live with
// zero connections; no clearing pass is run.
module backend_selector_rr_least_conn (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode[1:0], group_index[3:2], backend_index[6:4], alive[7]
    input  logic [bsel_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // found[0], chosen_backend[3:1], zero[7:4]
    output logic [bsel_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [bsel_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsel_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import bsel_pkg::*;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [GROUP_W-1:0]      g_reg, g_next;
    logic [BIDX_W-1:0]       b_reg, b_next;
    logic                    alive_reg, alive_next;

    logic [AG_W-1:0]         ag_reg;
    logic [MASK_W-1:0]       mask_reg;
    logic [BCNT_W-1:0]       bcnt_reg [NUM_CNT_REGS];

    logic [IDX_W-1:0]        rr_ptr_reg [NUM_GROUPS];
    logic                    row_vld_reg [NUM_GROUPS];
    row_t                    mem [NUM_GROUPS];
    row_t                    rd_row_reg;
    logic                    rd_vld_reg;

    cand_t                   cand_reg [NBP];
    cand_t                   cand_next [NBP];
    logic [LVL_W-1:0]        lvl_reg, lvl_next;

    logic                    res_found_reg, res_found_next;
    logic [BIDX_W-1:0]       res_idx_reg, res_idx_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg, m_found_next;
    logic [BIDX_W-1:0]       m_idx_reg, m_idx_next;

    logic                    mem_we;
    row_t                    wr_row;
    logic                    ptr_we;
    logic [IDX_W-1:0]        ptr_wdata;

    logic [G_W-1:0]          g_addr;
    logic                    grp_ok;
    logic [SIZE_W-1:0]       n_size;
    row_t                    row;
    logic [NUM_BACKENDS-1:0] live_mask;
    logic [IDX_W-1:0]        p0;
    logic                    hi_found, lo_found;
    logic [IDX_W-1:0]        hi_idx, lo_idx, rr_idx;
    logic [IDX_W-1:0]        b_addr;
    entry_t                  ent;
    logic                    upd_ok;

    assign g_addr   = G_W'(g_reg);
    assign b_addr   = IDX_W'(b_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - BIDX_W - 1)'(0), m_idx_reg, m_found_reg};

    always_comb begin
        grp_ok = (CMP_W'(g_reg) < CMP_W'(ag_reg)) && (CMP_W'(g_reg) < CMP_W'(NUM_GROUPS));
        if (CMP_W'(bcnt_reg[g_reg]) > CMP_W'(NUM_BACKENDS)) begin
            n_size = SIZE_W'(NUM_BACKENDS);
        end else begin
            n_size = SIZE_W'(bcnt_reg[g_reg]);
        end
        row = rd_vld_reg ? rd_row_reg : reset_row();
        upd_ok = grp_ok && (CMP_W'(b_reg) < CMP_W'(n_size));

        for (int i = 0; i < NUM_BACKENDS; i++) begin
            live_mask[i] = row[i].live && (i < int'(n_size));
        end
        p0 = (CMP_W'(rr_ptr_reg[g_addr]) >= CMP_W'(n_size)) ? '0 : rr_ptr_reg[g_addr];
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_idx   = '0;
        lo_idx   = '0;
        for (int i = NUM_BACKENDS - 1; i >= 0; i--) begin
            if (live_mask[i]) begin
                lo_found = 1'b1;
                lo_idx   = IDX_W'(i);
                if (IDX_W'(i) >= p0) begin
                    hi_found = 1'b1;
                    hi_idx   = IDX_W'(i);
                end
            end
        end
        rr_idx = hi_found ? hi_idx : lo_idx;

        ent = row[b_addr];
        case (op_reg)
            OP_OPEN: begin
                if (ent.cnt != '1) begin
                    ent.cnt = ent.cnt + 1'b1;
                end
            end
            OP_CLOSE: begin
                if (ent.cnt != '0) begin
                    ent.cnt = ent.cnt - 1'b1;
                end
            end
            OP_HEALTH: begin
                ent.live = alive_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        g_next         = g_reg;
        b_next         = b_reg;
        alive_next     = alive_reg;
        lvl_next       = lvl_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_idx_next     = m_idx_reg;
        mem_we         = 1'b0;
        wr_row         = row;
        ptr_we         = 1'b0;
        ptr_wdata      = p0;
        for (int i = 0; i < NBP; i++) begin
            cand_next[i] = cand_reg[i];
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tdata[1:0]);
                    g_next     = s_tdata[3:2];
                    b_next     = s_tdata[6:4];
                    alive_next = s_tdata[7];
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_OUT;
                if (op_reg == OP_SELECT) begin
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                    if (grp_ok && n_size != '0) begin
                        if (mask_reg[g_reg]) begin
                            for (int i = 0; i < NBP; i++) begin
                                cand_next[i].valid = (i < NUM_BACKENDS) && live_mask[i];
                                cand_next[i].cnt   = row[i % NUM_BACKENDS].cnt;
                                cand_next[i].idx   = IDX_W'(i);
                            end
                            lvl_next   = '0;
                            state_next = S_REDUCE;
                        end else begin
                            ptr_we         = 1'b1;
                            res_found_next = lo_found;
                            res_idx_next   = BIDX_W'(rr_idx);
                            if (lo_found) begin
                                ptr_wdata = (CMP_W'(rr_idx) + CMP_W'(1) >= CMP_W'(n_size))
                                            ? '0 : rr_idx + 1'b1;
                            end
                        end
                    end
                end else begin
                    res_found_next = upd_ok;
                    res_idx_next   = b_reg;
                    if (upd_ok) begin
                        mem_we         = 1'b1;
                        wr_row[b_addr] = ent;
                    end
                end
            end
            S_REDUCE: begin
                if (lvl_reg == LVL_W'(LVL)) begin
                    res_found_next = cand_reg[0].valid;
                    res_idx_next   = cand_reg[0].valid ? BIDX_W'(cand_reg[0].idx) : '0;
                    state_next     = S_OUT;
                end else begin
                    for (int i = 0; i < NBP; i++) begin
                        if (i < NBP / 2) begin
                            cand_next[i] = better(cand_reg[2 * i], cand_reg[2 * i + 1]);
                        end else begin
                            cand_next[i] = '0;
                        end
                    end
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_idx_next   = res_idx_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            ag_reg      <= '0;
            mask_reg    <= '0;
            for (int i = 0; i < NUM_CNT_REGS; i++) begin
                bcnt_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_GROUPS; i++) begin
                rr_ptr_reg[i]  <= '0;
                row_vld_reg[i] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACTIVE_GROUPS: ag_reg <= cfg_wdata[AG_W-1:0];
                    CFG_LC_MASK:       mask_reg <= cfg_wdata[MASK_W-1:0];
                    default: begin
                        if (cfg_index inside {[CFG_BACKENDS0:CFG_BACKENDS3]}) begin
                            bcnt_reg[2'(cfg_index - CFG_BACKENDS0)] <= cfg_wdata[BCNT_W-1:0];
                        end
                    end
                endcase
            end
            if (ptr_we) begin
                rr_ptr_reg[g_addr] <= ptr_wdata;
            end
            if (mem_we) begin
                row_vld_reg[g_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        g_reg         <= g_next;
        b_reg         <= b_next;
        alive_reg     <= alive_next;
        lvl_reg       <= lvl_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        m_found_reg   <= m_found_next;
        m_idx_reg     <= m_idx_next;
        for (int i = 0; i < NBP; i++) begin
            cand_reg[i] <= cand_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[g_addr] <= wr_row;
        end
        if (state_reg == S_READ) begin
            rd_row_reg <= mem[g_addr];
            rd_vld_reg <= row_vld_reg[g_addr];
        end
    end

    `ASSERT_NOW(a_busy_no_ready, state_reg != S_IDLE, !s_tready)
    `ASSERT_NOW(a_write_in_exec, mem_we || ptr_we, state_reg == S_EXEC)
    `ASSERT_NOW(a_ptr_in_range, ptr_we, CMP_W'(ptr_wdata) < CMP_W'(n_size))
    `ASSERT_NEXT(a_result_loaded, state_reg == S_OUT && (!m_valid_reg || m_tready), m_tvalid)

endmodule
